FILE: rtl/circular_queue_with_dump_macros.svh
// ----------------------------------------------------------------------------
// Circular queue assertion macros
// Shared concurrent-assertion shorthands, clocked on clk_i and held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_DUMP_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_DUMP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CQD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("circular queue: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CQD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("circular queue: next-cycle check failed");

`endif

FILE: rtl/cqd_pkg.sv
// ----------------------------------------------------------------------------
// Circular queue package
// Field widths, opcode and status codes, and the command and status
// structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package cqd_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 2;
  localparam int unsigned StsW  = 2;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_DELETE = 2'd1;
  localparam logic [OpW-1:0] OP_DUMP   = 2'd2;

  localparam logic [StsW-1:0] ST_OK        = 2'd0;
  localparam logic [StsW-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [StsW-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [StsW-1:0] ST_EMPTY     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            wr_en;       // store the input word at the tail
    logic            pop;         // read the head, advance it, one result to send
    logic            dump_start;  // read the head, walk all occupied slots
    logic            emit;        // send the read word, fetch the next one
    logic            imm_load;    // send a result without memory data
    logic [StsW-1:0] imm_status;
  } cqd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic remain_one;  // the word being sent is the final one of the item
    logic out_free;    // the output register can take a result this cycle
  } cqd_sts_t;

endpackage

FILE: rtl/cqd_ctrl.sv
// ----------------------------------------------------------------------------
// Circular queue controller
// Decodes each accepted transaction and sequences the memory reads that a
// delete or a dump needs.
// ----------------------------------------------------------------------------
module cqd_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_valid_i,
  input  logic [cqd_pkg::OpW-1:0]  s_opcode_i,
  output logic                     s_ready_o,
  input  cqd_pkg::cqd_sts_t        sts_i,
  output cqd_pkg::cqd_cmd_t        cmd_o
);
  import cqd_pkg::*;

  localparam logic StIdle   = 1'b0;
  localparam logic StStream = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign s_ready_o = (state_q == StIdle) && sts_i.out_free;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.imm_status = ST_OK;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (s_opcode_i)
            OP_INSERT: begin
              cmd_o.imm_load = 1'b1;
              if (sts_i.full) begin
                cmd_o.imm_status = ST_OVERFLOW;
              end else begin
                cmd_o.wr_en = 1'b1;
              end
            end
            OP_DELETE: begin
              if (sts_i.empty) begin
                cmd_o.imm_load   = 1'b1;
                cmd_o.imm_status = ST_UNDERFLOW;
              end else begin
                cmd_o.pop = 1'b1;
                state_d   = StStream;
              end
            end
            OP_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.imm_load   = 1'b1;
                cmd_o.imm_status = ST_EMPTY;
              end else begin
                cmd_o.dump_start = 1'b1;
                state_d          = StStream;
              end
            end
            default: begin
              // The unused opcode is dropped without a result.
            end
          endcase
        end
      end
      StStream: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.remain_one) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/cqd_dpath.sv
// ----------------------------------------------------------------------------
// Circular queue datapath
// Slot memory, head and tail pointers, occupancy count, dump walker and the
// output register.
// ----------------------------------------------------------------------------
`include "circular_queue_with_dump_macros.svh"

module cqd_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cqd_pkg::cqd_cmd_t         cmd_i,
  output cqd_pkg::cqd_sts_t         sts_o,
  input  logic [cqd_pkg::DataW-1:0] wr_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [cqd_pkg::StsW-1:0]  out_status_o,
  output logic [cqd_pkg::DataW-1:0] out_data_o,
  output logic                      out_last_o
);
  import cqd_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
    return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  logic [DataW-1:0] mem [DEPTH];
  logic [DataW-1:0] rd_q;
  logic [IW-1:0]    head_q, head_d, tail_q, tail_d, walk_q, walk_d, rd_addr;
  logic [OW-1:0]    occ_q, occ_d, remain_q, remain_d;
  logic             rd_en;
  logic             out_valid_q, out_valid_d, out_load;
  logic [StsW-1:0]  out_status_q;
  logic [DataW-1:0] out_data_q;
  logic             out_last_q;

  assign sts_o.full       = (occ_q == OW'(DEPTH));
  assign sts_o.empty      = (occ_q == '0);
  assign sts_o.remain_one = (remain_q == OW'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // The walker fetches the next slot as the current word leaves.
  assign rd_en   = cmd_i.pop || cmd_i.dump_start || (cmd_i.emit && !sts_o.remain_one);
  assign rd_addr = (cmd_i.emit) ? walk_q : head_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[tail_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    walk_d   = walk_q;
    remain_d = remain_q;
    if (cmd_i.wr_en) begin
      tail_d = next_idx(tail_q);
      occ_d  = occ_q + 1'b1;
    end
    if (cmd_i.pop) begin
      head_d   = next_idx(head_q);
      occ_d    = occ_q - 1'b1;
      walk_d   = next_idx(head_q);
      remain_d = OW'(1);
    end
    if (cmd_i.dump_start) begin
      walk_d   = next_idx(head_q);
      remain_d = occ_q;
    end
    if (cmd_i.emit && !sts_o.remain_one) begin
      walk_d   = next_idx(walk_q);
      remain_d = remain_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      occ_q    <= '0;
      walk_q   <= '0;
      remain_q <= '0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      occ_q    <= occ_d;
      walk_q   <= walk_d;
      remain_q <= remain_d;
    end
  end

  assign out_load    = cmd_i.emit || cmd_i.imm_load;
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= ST_OK;
      out_data_q   <= rd_q;
      out_last_q   <= sts_o.remain_one;
    end else if (cmd_i.imm_load) begin
      out_status_q <= cmd_i.imm_status;
      out_data_q   <= '0;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;
  assign out_last_o   = out_last_q;

  `CQD_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OW'(DEPTH))
  `CQD_ASSERT_NOW(a_no_write_full, cmd_i.wr_en, !sts_o.full)
  `CQD_ASSERT_NOW(a_no_read_empty, cmd_i.pop || cmd_i.dump_start, !sts_o.empty)
  `CQD_ASSERT_NOW(a_load_when_free, out_load, sts_o.out_free)
  `CQD_ASSERT_NEXT(a_final_marked, cmd_i.emit && sts_o.remain_one, out_valid_q && out_last_q)

endmodule

FILE: rtl/circular_queue_with_dump.sv
// ----------------------------------------------------------------------------
// Circular queue with dump
// Ring-buffer FIFO of signed 32-bit words with insert, delete and an
// in-order dump of all stored words.
//
//   Channel   Direction  tdata            tuser            tlast
//   s_axis    in         data_in[31:0]    opcode[1:0]      -
//   m_axis    out        data_out[31:0]   status[1:0]      last
//
// Insert and every error or empty result load the output register directly;
// delete and dump first read the head through the registered memory read port.
// The dump walker sends one word per cycle while m_axis is not stalled.
// A result held by a stalled m_axis keeps s_axis_tready low until it leaves.
// Reset clears the pointers and the count; slot contents are not cleared.
// ----------------------------------------------------------------------------
module circular_queue_with_dump #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [cqd_pkg::DataW-1:0] s_axis_tdata,   // [31:0] data_in
  input  logic [cqd_pkg::OpW-1:0]   s_axis_tuser,   // [1:0] opcode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [cqd_pkg::DataW-1:0] m_axis_tdata,   // [31:0] data_out
  output logic [cqd_pkg::StsW-1:0]  m_axis_tuser,   // [1:0] status
  output logic                      m_axis_tlast
);
  import cqd_pkg::*;

  cqd_cmd_t cmd;
  cqd_sts_t sts;

  cqd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_opcode_i (s_axis_tuser),
    .s_ready_o  (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cqd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .wr_data_i    (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule
